// ----- sv/dfl_pkg.sv -----
// Shared types, register codes and exp tables for the box decoder.
package dfl_pkg;

  localparam logic [2:0] CFG_CLASS_COUNT     = 3'd0;
  localparam logic [2:0] CFG_BINS_PER_SIDE   = 3'd1;
  localparam logic [2:0] CFG_GRID_WIDTH      = 3'd2;
  localparam logic [2:0] CFG_GRID_HEIGHT     = 3'd3;
  localparam logic [2:0] CFG_STRIDE_LOG2     = 3'd4;
  localparam logic [2:0] CFG_LOGIT_THRESHOLD = 3'd5;

  typedef struct packed {
    logic accept;
    logic mul;
    logic exp1;
    logic exp_logit;
    logic exp2;
    logic acc;
    logic div_start;
    logic div_score;
    logic div_store;
    logic emit;
    logic cell_done;
  } dfl_cmd_t;

  typedef struct packed {
    logic in_is_bin;
    logic in_last;
    logic last;
    logic keep;
    logic side_last;
    logic extent_ok;
    logic div_done;
    logic out_free;
  } dfl_sts_t;

  // exp of the integer part, Q.24
  function automatic logic [34:0] exp_int(input logic [3:0] i);
    logic [34:0] r;
    unique case (i)
      4'd0:  r = 35'd5628;
      4'd1:  r = 35'd15299;
      4'd2:  r = 35'd41587;
      4'd3:  r = 35'd113044;
      4'd4:  r = 35'd307285;
      4'd5:  r = 35'd835288;
      4'd6:  r = 35'd2270549;
      4'd7:  r = 35'd6171993;
      4'd8:  r = 35'd16777216;
      4'd9:  r = 35'd45605201;
      4'd10: r = 35'd123967790;
      4'd11: r = 35'd336979391;
      4'd12: r = 35'd916004956;
      4'd13: r = 35'd2489959627;
      4'd14: r = 35'd6768412009;
      default: r = 35'd18398451365;
    endcase
    return r;
  endfunction

  // exp of the upper fraction nibble, Q.14
  function automatic logic [15:0] exp_hi(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0:  r = 16'd16384;
      4'd1:  r = 16'd17441;
      4'd2:  r = 16'd18566;
      4'd3:  r = 16'd19763;
      4'd4:  r = 16'd21037;
      4'd5:  r = 16'd22394;
      4'd6:  r = 16'd23839;
      4'd7:  r = 16'd25376;
      4'd8:  r = 16'd27013;
      4'd9:  r = 16'd28755;
      4'd10: r = 16'd30609;
      4'd11: r = 16'd32583;
      4'd12: r = 16'd34685;
      4'd13: r = 16'd36922;
      4'd14: r = 16'd39303;
      default: r = 16'd41838;
    endcase
    return r;
  endfunction

  // exp of the lower fraction nibble, Q.15
  function automatic logic [15:0] exp_lo(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0:  r = 16'd32768;
      4'd1:  r = 16'd32896;
      4'd2:  r = 16'd33025;
      4'd3:  r = 16'd33154;
      4'd4:  r = 16'd33284;
      4'd5:  r = 16'd33414;
      4'd6:  r = 16'd33545;
      4'd7:  r = 16'd33676;
      4'd8:  r = 16'd33808;
      4'd9:  r = 16'd33940;
      4'd10: r = 16'd34073;
      4'd11: r = 16'd34207;
      4'd12: r = 16'd34341;
      4'd13: r = 16'd34475;
      4'd14: r = 16'd34610;
      default: r = 16'd34745;
    endcase
    return r;
  endfunction

  // zero reads as one, values above the limit read as the limit
  function automatic logic [8:0] limit_reg(input logic [7:0] v, input int unsigned top);
    logic [8:0] r;
    if (v == 8'd0) r = 9'd1;
    else if (32'(v) > top) r = top[8:0];
    else r = {1'b0, v};
    return r;
  endfunction

endpackage

// ----- sv/dfl_in_if.sv -----
// Input element channel.
interface dfl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [23:0]        bin_scale;
  logic               map_start;
  modport source (output valid, value, bin_scale, map_start, input ready);
  modport sink (input valid, value, bin_scale, map_start, output ready);
endinterface

// ----- sv/dfl_out_if.sv -----
// Detection result channel.
interface dfl_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         class_id;
  logic [15:0]        score;
  logic signed [16:0] left_x;
  logic signed [16:0] top_y;
  logic signed [16:0] right_x;
  logic signed [16:0] bottom_y;
  modport source (output valid, class_id, score, left_x, top_y, right_x, bottom_y,
                  input ready);
  modport sink (input valid, class_id, score, left_x, top_y, right_x, bottom_y,
                output ready);
endinterface

// ----- sv/dfl_cfg_if.sv -----
// Configuration write channel.
interface dfl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/dfl_box_decode.sv -----
// Top level of the detection-head box decoder.
// Decodes a detection-head feature map one tensor element per transfer. A cell is
// class_count Q8.8 logits followed by four sides (left, top, right, bottom) of
// bins_per_side quantized bins. The first strictly greatest logit picks the class;
// a cell whose best logit is below logit_threshold is dropped. Each side's distance
// is the softmax expectation of its bins, using a three-table exp of the clamped Q8.8
// bin value. Cells of zero width or height are dropped; a kept cell yields one result
// with the class, the sigmoid score in Q0.16 and four stride-scaled corners in
// saturated Q12.4. A logit element needs no stage after it is accepted; a bin element
// then passes one multiply stage, two exp table stages and the accumulate. At the end
// of a kept cell a shared serial divider (16 quotient bits) runs four distance
// divisions and, if the extent is nonzero, one score division. A result waits in an
// output register while the next cell streams in; the end-of-cell sequence holds
// only when a new result is ready and the previous one has not been taken yet.
// Register writes are taken while no element is being processed and win over a
// waiting element; a write to one of the six register codes restarts the current
// cell. map_start puts the element at row 0, column 0 as the first of a new cell.
module dfl_box_decode #(
  parameter int unsigned MAX_CLASSES = 128,
  parameter int unsigned MAX_BINS    = 32,
  parameter int unsigned MAX_GRID    = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  dfl_in_if.sink    in_ch,
  dfl_out_if.source out_ch,
  dfl_cfg_if.sink   cfg_ch
);
  import dfl_pkg::*;

  dfl_cmd_t cmd;
  dfl_sts_t sts;
  logic     in_ready, cfg_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = cfg_ready;

  // controller: one element at a time, then the end-of-cell sequence
  dfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: registers, accumulators, exp, divider and the result register
  dfl_dp #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_BINS    (MAX_BINS),
    .MAX_GRID    (MAX_GRID)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_ch.valid && cfg_ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .in_value     (in_ch.value),
    .in_bin_scale (in_ch.bin_scale),
    .in_map_start (in_ch.map_start),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_class_id (out_ch.class_id),
    .out_score    (out_ch.score),
    .out_left_x   (out_ch.left_x),
    .out_top_y    (out_ch.top_y),
    .out_right_x  (out_ch.right_x),
    .out_bottom_y (out_ch.bottom_y)
  );
endmodule

// ----- sv/dfl_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module dfl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [15:0] quo
);
  import dfl_pkg::*;

  logic [32:0] rem_r, rem_nxt;
  logic [15:0] low_r, q_r;
  logic [32:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r, zero_r;
  logic [33:0] sh;
  logic        qbit;

  always_comb begin
    sh   = {rem_r, low_r[15]};
    qbit = (sh >= {1'b0, den_r});
    rem_nxt = qbit ? 33'(sh - {1'b0, den_r}) : sh[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'd16;
      rem_r  <= num[48:16];
      low_r  <= num[15:0];
      den_r  <= den;
      zero_r <= (den == 33'd0);
      q_r    <= 16'd0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[14:0], 1'b0};
      q_r   <= {q_r[14:0], qbit};
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? 16'd0 : q_r;
endmodule

// ----- sv/dfl_dp.sv -----
// Datapath: config registers, cell accumulators, exp pipeline, corners and result register.
module dfl_dp #(
  parameter int unsigned MAX_CLASSES = 128,
  parameter int unsigned MAX_BINS    = 32,
  parameter int unsigned MAX_GRID    = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dfl_pkg::dfl_cmd_t  cmd,
  output dfl_pkg::dfl_sts_t  sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [31:0] in_value,
  input  logic [23:0]        in_bin_scale,
  input  logic               in_map_start,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [6:0]         out_class_id,
  output logic [15:0]        out_score,
  output logic signed [16:0] out_left_x,
  output logic signed [16:0] out_top_y,
  output logic signed [16:0] out_right_x,
  output logic signed [16:0] out_bottom_y
);
  import dfl_pkg::*;

  logic [7:0]         class_count_r, grid_width_r, grid_height_r;
  logic [5:0]         bins_r;
  logic [2:0]         stride_r;
  logic signed [15:0] thr_r;

  logic [8:0]         elem_idx_r, side_bin_dummy;
  logic [1:0]         side_r, k_r;
  logic [5:0]         bin_r;
  logic [6:0]         best_class_r;
  logic signed [15:0] best_logit_r;
  logic [31:0]        wsum_r [4];
  logic [39:0]        msum_r [4];
  logic [7:0]         col_r, row_r;
  logic [15:0]        d_r [4];
  logic [15:0]        score_r;

  logic signed [31:0] value_r;
  logic [23:0]        scale_r;
  logic               last_r;
  logic signed [56:0] prod_r;
  logic [35:0]        t1_r;
  logic [3:0]         l_r;
  logic [31:0]        w_r;

  logic               out_valid_r;
  logic [6:0]         o_class_r;
  logic [15:0]        o_score_r;
  logic [16:0]        o_lx_r, o_ty_r, o_rx_r, o_by_r;

  logic [8:0]  nc, nb, gwl, ghl;
  logic [9:0]  cell_len;
  logic [8:0]  p;
  logic        p_logit, p_last;
  logic signed [15:0] lg_sat, x_in, x_c;
  logic [11:0] u;
  logic [50:0] m1;
  logic [51:0] m2;
  logic [48:0] div_num;
  logic [32:0] div_den, den_s;
  logic        div_done;
  logic [15:0] quo;
  logic signed [18:0] cx, cy;

  assign side_bin_dummy = {3'd0, bin_r};

  always_comb begin
    nc  = limit_reg(class_count_r, MAX_CLASSES);
    nb  = limit_reg({2'b00, bins_r}, MAX_BINS);
    gwl = limit_reg(grid_width_r, MAX_GRID);
    ghl = limit_reg(grid_height_r, MAX_GRID);
    cell_len = {1'b0, nc} + {nb[7:0], 2'b00};
    p = in_map_start ? 9'd0 : elem_idx_r;
    p_logit = (p < nc);
    p_last  = ({1'b0, p} + 10'd1 >= cell_len);
    if (in_value < -32'sd32768) lg_sat = -16'sd32768;
    else if (in_value > 32'sd32767) lg_sat = 16'sd32767;
    else lg_sat = in_value[15:0];
  end

  // exp input: clamped Q8.8 value from the bin product or the winning logit
  always_comb begin
    if (prod_r < -57'sd134217728) x_in = -16'sd2048;
    else if (prod_r >= 57'sd117506048) x_in = 16'sd1792;
    else x_in = 16'(prod_r >>> 16);
    if (cmd.exp_logit) x_in = best_logit_r;
    if (x_in < -16'sd2048) x_c = -16'sd2048;
    else if (x_in > 16'sd1792) x_c = 16'sd1792;
    else x_c = x_in;
    u  = 12'(x_c + 16'sd2048);
    m1 = 51'(exp_int(u[11:8])) * 51'(exp_hi(u[7:4])) + 51'd8192;
    m2 = 52'(t1_r) * 52'(exp_lo(l_r)) + 52'd4194304;
  end

  always_comb begin
    den_s = {1'b0, w_r} + 33'd65536;
    if (cmd.div_score) begin
      div_num = {1'b0, w_r, 16'd0} + 49'(den_s >> 1);
      div_den = den_s;
    end else begin
      div_num = {1'b0, msum_r[k_r], 8'd0} + 49'(wsum_r[k_r] >> 1);
      div_den = {1'b0, wsum_r[k_r]};
    end
  end

  dfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  function automatic logic [16:0] corner(input logic signed [18:0] q8, input logic [2:0] sh);
    logic signed [25:0] s;
    logic signed [21:0] v;
    logic [16:0] r;
    s = 26'(q8) <<< sh;
    v = 22'((s + 26'sd8) >>> 4);
    if (v < -22'sd65536) r = 17'h10000;
    else if (v > 22'sd65535) r = 17'h0FFFF;
    else r = v[16:0];
    return r;
  endfunction

  always_comb begin
    cx = 19'({1'b0, col_r, 8'd0} + 17'd128);
    cy = 19'({1'b0, row_r, 8'd0} + 17'd128);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= 8'd80;
      bins_r        <= 6'd16;
      grid_width_r  <= 8'd80;
      grid_height_r <= 8'd80;
      stride_r      <= 3'd3;
      thr_r         <= -16'sd281;
      elem_idx_r    <= 9'd0;
      side_r        <= 2'd0;
      bin_r         <= 6'd0;
      k_r           <= 2'd0;
      best_class_r  <= 7'd0;
      best_logit_r  <= 16'sd0;
      col_r         <= 8'd0;
      row_r         <= 8'd0;
      out_valid_r   <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        wsum_r[k] <= 32'd0;
        msum_r[k] <= 40'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLASS_COUNT:     class_count_r <= cfg_data[7:0];
          CFG_BINS_PER_SIDE:   bins_r        <= cfg_data[5:0];
          CFG_GRID_WIDTH:      grid_width_r  <= cfg_data[7:0];
          CFG_GRID_HEIGHT:     grid_height_r <= cfg_data[7:0];
          CFG_STRIDE_LOG2:     stride_r      <= cfg_data[2:0];
          CFG_LOGIT_THRESHOLD: thr_r         <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= CFG_LOGIT_THRESHOLD) begin
          elem_idx_r <= 9'd0;
          side_r     <= 2'd0;
          bin_r      <= 6'd0;
          for (int k = 0; k < 4; k++) begin
            wsum_r[k] <= 32'd0;
            msum_r[k] <= 40'd0;
          end
        end
      end

      if (cmd.accept) begin
        value_r <= in_value;
        scale_r <= in_bin_scale;
        last_r  <= p_last;
        k_r     <= 2'd0;
        elem_idx_r <= p_last ? 9'd0 : 9'(p + 9'd1);
        if (in_map_start) begin
          col_r <= 8'd0;
          row_r <= 8'd0;
        end
        if (p == 9'd0) begin
          side_r <= 2'd0;
          bin_r  <= 6'd0;
          for (int k = 0; k < 4; k++) begin
            wsum_r[k] <= 32'd0;
            msum_r[k] <= 40'd0;
          end
        end
        if (p_logit && (p == 9'd0 || lg_sat > best_logit_r)) begin
          best_logit_r <= lg_sat;
          best_class_r <= p[6:0];
        end
      end

      if (cmd.mul) prod_r <= value_r * $signed({1'b0, scale_r});
      if (cmd.exp1) begin
        t1_r <= m1[49:14];
        l_r  <= u[3:0];
      end
      if (cmd.exp2) w_r <= {3'd0, m2[51:23]};

      if (cmd.acc) begin
        wsum_r[side_r] <= wsum_r[side_r] + w_r;
        msum_r[side_r] <= msum_r[side_r] + 40'(w_r) * 40'(bin_r);
        if (side_bin_dummy + 9'd1 == nb) begin
          bin_r  <= 6'd0;
          side_r <= side_r + 2'd1;
        end else begin
          bin_r <= bin_r + 6'd1;
        end
      end

      if (cmd.div_store) begin
        if (cmd.div_score) begin
          score_r <= quo;
        end else begin
          d_r[k_r] <= quo;
          k_r      <= k_r + 2'd1;
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        o_class_r   <= best_class_r;
        o_score_r   <= score_r;
        o_lx_r      <= corner(cx - 19'(d_r[0]), stride_r);
        o_ty_r      <= corner(cy - 19'(d_r[1]), stride_r);
        o_rx_r      <= corner(cx + 19'(d_r[2]), stride_r);
        o_by_r      <= corner(cy + 19'(d_r[3]), stride_r);
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.cell_done) begin
        side_r <= 2'd0;
        bin_r  <= 6'd0;
        for (int k = 0; k < 4; k++) begin
          wsum_r[k] <= 32'd0;
          msum_r[k] <= 40'd0;
        end
        if ({1'b0, col_r} + 9'd1 >= gwl) begin
          col_r <= 8'd0;
          if ({1'b0, row_r} + 9'd1 >= ghl) row_r <= 8'd0;
          else row_r <= row_r + 8'd1;
        end else begin
          col_r <= col_r + 8'd1;
        end
      end
    end
  end

  always_comb begin
    sts.in_is_bin = !p_logit;
    sts.in_last   = p_last;
    sts.last      = last_r;
    sts.keep      = (best_logit_r >= thr_r);
    sts.side_last = (k_r == 2'd3);
    sts.extent_ok = ((d_r[0] != 16'd0) || (d_r[2] != 16'd0)) &&
                    ((d_r[1] != 16'd0) || (d_r[3] != 16'd0));
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_class_id = o_class_r;
  assign out_score    = o_score_r;
  assign out_left_x   = o_lx_r;
  assign out_top_y    = o_ty_r;
  assign out_right_x  = o_rx_r;
  assign out_bottom_y = o_by_r;
endmodule

// ----- sv/dfl_ctrl.sv -----
// Controller: sequences element accumulation and the end-of-cell divisions.
module dfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  dfl_pkg::dfl_sts_t sts,
  output dfl_pkg::dfl_cmd_t cmd
);
  import dfl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_EXP1   = 4'd2;
  localparam logic [3:0] S_EXP2   = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_END    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_CHKZ   = 4'd8;
  localparam logic [3:0] S_SEXP1  = 4'd9;
  localparam logic [3:0] S_SEXP2  = 4'd10;
  localparam logic [3:0] S_SSTART = 4'd11;
  localparam logic [3:0] S_SWAIT  = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_r, state_nxt;

  // a register write takes priority over a waiting element
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_is_bin) state_nxt = S_MUL;
          else if (sts.in_last) state_nxt = S_END;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EXP1;
      end
      S_EXP1: begin
        cmd.exp1  = 1'b1;
        state_nxt = S_EXP2;
      end
      S_EXP2: begin
        cmd.exp2  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_END : S_IDLE;
      end
      S_END:    state_nxt = sts.keep ? S_DSTART : S_DONE;
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = sts.side_last ? S_CHKZ : S_DSTART;
        end
      end
      S_CHKZ:   state_nxt = sts.extent_ok ? S_SEXP1 : S_DONE;
      S_SEXP1: begin
        cmd.exp1      = 1'b1;
        cmd.exp_logit = 1'b1;
        state_nxt     = S_SEXP2;
      end
      S_SEXP2: begin
        cmd.exp2  = 1'b1;
        state_nxt = S_SSTART;
      end
      S_SSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_score = 1'b1;
        state_nxt     = S_SWAIT;
      end
      S_SWAIT: begin
        cmd.div_score = 1'b1;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.cell_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
